@@ hw/rtl/irm_pkg.sv @@
// shared types and constants for the interval range map
package irm_pkg;

  localparam int unsigned CapacityDef  = 64;
  localparam int unsigned KeyBitsDef   = 32;
  localparam int unsigned ValueBitsDef = 8;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } irm_status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_MOVE,
    S_WR_START,
    S_WR_END,
    S_RESULT
  } irm_state_e;

endpackage

@@ hw/rtl/irm_engine.sv @@
// breakpoint table memory with scan, shift and insert sequencer
module irm_engine #(
  parameter int unsigned CAPACITY   = irm_pkg::CapacityDef,
  parameter int unsigned KEY_BITS   = irm_pkg::KeyBitsDef,
  parameter int unsigned VALUE_BITS = irm_pkg::ValueBitsDef
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic                  mode_i,
  input  logic [KEY_BITS-1:0]   key_begin_i,
  input  logic [KEY_BITS-1:0]   key_end_i,
  input  logic [VALUE_BITS-1:0] value_i,
  input  logic [VALUE_BITS-1:0] default_value_i,
  output logic                  idle_o,
  output logic                  res_valid_o,
  input  logic                  res_take_i,
  output logic [VALUE_BITS-1:0] res_value_o,
  output irm_pkg::irm_status_e  res_status_o
);
  import irm_pkg::*;

  localparam int unsigned IdxW  = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CntW  = $clog2(CAPACITY + 1);
  localparam int unsigned DW    = CntW + 2;
  localparam int unsigned WordW = KEY_BITS + VALUE_BITS;
  localparam logic [CntW:0] CapN = (CntW + 1)'(CAPACITY);

  logic [WordW-1:0] mem [CAPACITY];
  logic [WordW-1:0] rdata_q;

  irm_state_e state_q, state_d;
  logic                  mode_q;
  logic [KEY_BITS-1:0]   kb_q, ke_q;
  logic [VALUE_BITS-1:0] v_q, prev_q, lkval_q, endv_q, res_value_q;
  irm_status_e           res_status_q;
  logic [CntW-1:0]       count_q, rd_idx_q, lo_q, hi_q, n_q, mv_idx_q, mv_left_q;
  logic                  pend_q, s_q, e_q;
  logic [IdxW-1:0]       pend_addr_q;
  logic signed [DW-1:0]  delta_q;

  logic                  ren, wen;
  logic [IdxW-1:0]       raddr, waddr;
  logic [WordW-1:0]      wdata;

  logic [KEY_BITS-1:0]   rd_key;
  logic [VALUE_BITS-1:0] rd_val;
  logic                  scan_end, s_c, e_c, full_c, move_end;
  logic [CntW:0]         n_c;
  logic signed [DW-1:0]  delta_c, waddr_w;

  assign rd_key = rdata_q[WordW-1:VALUE_BITS];
  assign rd_val = rdata_q[VALUE_BITS-1:0];

  // plan of the rewrite, valid at the end of the scan
  assign scan_end = (state_q == S_SCAN) && (rd_idx_q == count_q) && !pend_q;
  assign s_c      = (prev_q != v_q);
  assign e_c      = (endv_q != v_q);
  assign n_c      = {1'b0, count_q} - {1'b0, hi_q} + {1'b0, lo_q}
                    + (CntW + 1)'(s_c) + (CntW + 1)'(e_c);
  assign full_c   = n_c > CapN;
  assign delta_c  = DW'(s_c) + DW'(e_c) - DW'(hi_q) + DW'(lo_q);
  assign move_end = (mv_left_q == '0) && !pend_q;
  assign waddr_w  = DW'(pend_addr_q) + delta_q;

  always_ff @(posedge clk_i) begin
    if (ren) begin
      rdata_q <= mem[raddr];
    end
    if (wen) begin
      mem[waddr] <= wdata;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          if (mode_i && !($signed(key_begin_i) < $signed(key_end_i))) state_d = S_RESULT;
          else state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        if (scan_end) begin
          if (!mode_q || full_c) state_d = S_RESULT;
          else state_d = S_MOVE;
        end
      end
      S_MOVE:     if (move_end) state_d = S_WR_START;
      S_WR_START: state_d = S_WR_END;
      S_WR_END:   state_d = S_RESULT;
      S_RESULT:   if (res_take_i) state_d = S_IDLE;
      default:    state_d = S_IDLE;
    endcase
  end

  // memory port control
  always_comb begin
    ren   = 1'b0;
    raddr = '0;
    wen   = 1'b0;
    waddr = '0;
    wdata = '0;
    case (state_q)
      S_SCAN: begin
        ren   = rd_idx_q < count_q;
        raddr = rd_idx_q[IdxW-1:0];
      end
      S_MOVE: begin
        ren   = mv_left_q != '0;
        raddr = mv_idx_q[IdxW-1:0];
        wen   = pend_q;
        waddr = waddr_w[IdxW-1:0];
        wdata = rdata_q;
      end
      S_WR_START: begin
        wen   = s_q;
        waddr = lo_q[IdxW-1:0];
        wdata = {kb_q, v_q};
      end
      S_WR_END: begin
        wen   = e_q;
        waddr = IdxW'(lo_q + CntW'(s_q));
        wdata = {ke_q, endv_q};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      count_q  <= '0;
      pend_q   <= 1'b0;
      rd_idx_q <= '0;
      mv_left_q <= '0;
    end else begin
      state_q <= state_d;
      case (state_q)
        S_IDLE: begin
          if (start_i) begin
            mode_q   <= mode_i;
            kb_q     <= key_begin_i;
            ke_q     <= key_end_i;
            v_q      <= value_i;
            prev_q   <= default_value_i;
            lkval_q  <= default_value_i;
            endv_q   <= default_value_i;
            lo_q     <= '0;
            hi_q     <= '0;
            rd_idx_q <= '0;
            pend_q   <= 1'b0;
            res_value_q  <= '0;
            res_status_q <= ST_EMPTY;
          end
        end
        S_SCAN: begin
          pend_q <= ren;
          if (ren) rd_idx_q <= rd_idx_q + 1'b1;
          if (pend_q) begin
            if ($signed(rd_key) < $signed(kb_q)) begin
              lo_q   <= lo_q + 1'b1;
              prev_q <= rd_val;
            end
            if ($signed(rd_key) <= $signed(kb_q)) lkval_q <= rd_val;
            if ($signed(rd_key) <= $signed(ke_q)) begin
              hi_q   <= hi_q + 1'b1;
              endv_q <= rd_val;
            end
          end
          if (scan_end) begin
            s_q     <= s_c;
            e_q     <= e_c;
            n_q     <= n_c[CntW-1:0];
            delta_q <= delta_c;
            mv_left_q <= (delta_c == '0) ? '0 : count_q - hi_q;
            mv_idx_q  <= (delta_c > 0) ? count_q - 1'b1 : hi_q;
            if (!mode_q) begin
              res_value_q  <= lkval_q;
              res_status_q <= ST_DONE;
            end else begin
              res_value_q  <= '0;
              res_status_q <= full_c ? ST_FULL : ST_DONE;
            end
          end
        end
        S_MOVE: begin
          pend_q <= ren;
          if (ren) begin
            pend_addr_q <= mv_idx_q[IdxW-1:0];
            mv_left_q   <= mv_left_q - 1'b1;
            mv_idx_q    <= (delta_q > 0) ? mv_idx_q - 1'b1 : mv_idx_q + 1'b1;
          end
        end
        S_WR_END: count_q <= n_q;
        default: ;
      endcase
    end
  end

  assign idle_o       = state_q == S_IDLE;
  assign res_valid_o  = state_q == S_RESULT;
  assign res_value_o  = res_value_q;
  assign res_status_o = res_status_q;

endmodule

@@ hw/rtl/interval_range_map_core.sv @@
// top level of the interval range map: handshakes, config register, result register
//
// channel   direction  handshake               payload
// in        input      in_valid_i / in_stall_o  mode_i key_begin_i key_end_i value_i
// out       output     out_valid_o / out_stall_i read_value_o status_o
// cfg       input      apb write, pready high   default_value at offset 0
//
// one item at a time; a lookup reads the breakpoints one by one, bound by the single
// read port walking the breakpoint memory; an assign that fits also moves each
// breakpoint above the range when the fill count changes, then up to two insert writes
// reset empties the table at once through the fill count, no clearing pass
// one result can wait in the output register while the next item runs; a second
// finished result held by a stalled output keeps the input stalled
module interval_range_map_core #(
  parameter int unsigned CAPACITY   = irm_pkg::CapacityDef,
  parameter int unsigned KEY_BITS   = irm_pkg::KeyBitsDef,
  parameter int unsigned VALUE_BITS = irm_pkg::ValueBitsDef,
  localparam int unsigned DataW = (VALUE_BITS > 32) ? 64 : 32,
  localparam int unsigned AddrW = (VALUE_BITS > 32) ? 4 : 3
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic                  mode_i,
  input  logic [KEY_BITS-1:0]   key_begin_i,
  input  logic [KEY_BITS-1:0]   key_end_i,
  input  logic [VALUE_BITS-1:0] value_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output logic [VALUE_BITS-1:0] read_value_o,
  output logic [1:0]            status_o,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [AddrW-1:0]      paddr,
  input  logic [DataW-1:0]      pwdata,
  output logic [DataW-1:0]      prdata,
  output logic                  pready
);
  import irm_pkg::*;

  logic [VALUE_BITS-1:0] default_q;
  logic                  eng_idle, res_valid, res_take, in_xfer;
  logic [VALUE_BITS-1:0] res_value;
  irm_status_e           res_status;
  logic                  out_valid_q;
  logic [VALUE_BITS-1:0] read_value_q;
  irm_status_e           status_q;

  // config register at offset 0, aliased over offsets with the top address bit clear; offsets with it set read as zero
  assign pready = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      default_q <= '0;
    end else if (psel && penable && pwrite && !paddr[AddrW-1]) begin
      default_q <= pwdata[VALUE_BITS-1:0];
    end
  end
  assign prdata = paddr[AddrW-1] ? '0 : DataW'(default_q);

  // input transfer only while the sequencer is idle
  assign in_stall_o = !eng_idle;
  assign in_xfer    = in_valid_i && !in_stall_o;

  irm_engine #(
    .CAPACITY  (CAPACITY),
    .KEY_BITS  (KEY_BITS),
    .VALUE_BITS(VALUE_BITS)
  ) u_engine (
    .clk_i,
    .rst_ni,
    .start_i        (in_xfer),
    .mode_i,
    .key_begin_i,
    .key_end_i,
    .value_i,
    .default_value_i(default_q),
    .idle_o         (eng_idle),
    .res_valid_o    (res_valid),
    .res_take_i     (res_take),
    .res_value_o    (res_value),
    .res_status_o   (res_status)
  );

  // output register; refills in the cycle the old result leaves
  assign res_take = res_valid && (!out_valid_q || !out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_take) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_take) begin
      read_value_q <= res_value;
      status_q     <= res_status;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign read_value_o = read_value_q;
  assign status_o     = status_q;

  // an accepted item keeps the input closed in the next cycle
  a_busy_after_xfer: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> in_stall_o)
    else $error("input open right after a transfer");

  // only defined status codes leave the block
  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (status_o == ST_DONE || status_o == ST_EMPTY || status_o == ST_FULL))
    else $error("undefined status code");

  // non-done results carry a zero value
  a_zero_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && status_o != ST_DONE) |-> (read_value_o == '0))
    else $error("nonzero value with error status");

endmodule
